>>> src/cic_pkg.sv
// ----------------------------------------------------------------------------
// cic_pkg: shared types and constants for the charge deposition block
// Widths, operation and register codes, and the queue entry passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package cic_pkg;

  // Grid geometry
  localparam int GRID_POINTS = 1024;
  localparam int GRID_AW     = $clog2(GRID_POINTS);
  localparam int BANK_DEPTH  = GRID_POINTS / 2;
  localparam int BANK_AW     = GRID_AW - 1;

  // Field widths
  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = 28;
  localparam int CELL_W     = POS_W - FRAC_BITS;
  localparam int WEIGHT_W   = 18;
  localparam int SCALE_W    = 24;
  localparam int LGP_W      = 10;
  localparam int OP_W       = 2;
  localparam int ACC_W      = 40;

  // Arithmetic widths
  localparam int PROD_W     = WEIGHT_W + 1 + SCALE_W;   // weight * charge_scale
  localparam int W_W        = PROD_W - FRAC_BITS - 1;   // rounded particle charge
  localparam int MPROD_W    = W_W + FRAC_BITS + 1;      // charge * offset
  localparam int SHARE_W    = MPROD_W - FRAC_BITS;      // share of one grid point

  // Port widths
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_AW      = 1;
  localparam int CFG_DW      = 24;

  // Queue between front and back end
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Operation codes
  localparam logic [OP_W-1:0] OP_DEPOSIT    = 2'd0;
  localparam logic [OP_W-1:0] OP_READ       = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd2;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_CHARGE_SCALE    = 1'd0;
  localparam logic [CFG_AW-1:0] REG_LAST_GRID_POINT = 1'd1;

  // Register reset values
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
  localparam logic [LGP_W-1:0]   LGP_RESET   = 10'd1023;

  // Work kinds decided by the front end
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] K_NONE       = 3'd0;
  localparam logic [KIND_W-1:0] K_DEPOSIT    = 3'd1;
  localparam logic [KIND_W-1:0] K_DROP       = 3'd2;
  localparam logic [KIND_W-1:0] K_READ       = 3'd3;
  localparam logic [KIND_W-1:0] K_READ_CLEAR = 3'd4;

  // Saturation limits
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [GRID_AW-1:0]   cell_idx;
    logic [FRAC_BITS-1:0] frac;
    logic [PROD_W-1:0]    prod;
    logic [GRID_AW-1:0]   gidx;
    logic                 last;
  } q_entry_t;

endpackage

>>> src/cic_ram.sv
// ----------------------------------------------------------------------------
// cic_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds while the
// read enable is low.
// ----------------------------------------------------------------------------
module cic_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 512,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/cic_front.sv
// ----------------------------------------------------------------------------
// cic_front: input acceptance and classification
// Holds the configuration registers, decodes each transaction, checks the
// deposit cell range and forms weight * charge_scale for the queue.
// ----------------------------------------------------------------------------
module cic_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cic_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [cic_pkg::OP_W-1:0]      in_tuser,
  input  logic                          in_tlast,
  input  logic                          cfg_we,
  input  logic [cic_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [cic_pkg::CFG_DW-1:0]    cfg_wdata,
  input  logic                          init_done,
  input  logic                          q_full,
  output logic                          q_push,
  output cic_pkg::q_entry_t             q_data
);

  import cic_pkg::*;

  logic signed [SCALE_W-1:0]  scale_r;
  logic [LGP_W-1:0]           lgp_r;
  logic [POS_W-1:0]           position;
  logic [WEIGHT_W-1:0]        weight;
  logic [GRID_AW-1:0]         gidx;
  logic [CELL_W-1:0]          cell_idx;
  logic                       in_range;
  logic signed [PROD_W-1:0]   prod;
  logic [KIND_W-1:0]          kind;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
      lgp_r   <= LGP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CHARGE_SCALE:    scale_r <= cfg_wdata[SCALE_W-1:0];
        REG_LAST_GRID_POINT: lgp_r   <= cfg_wdata[LGP_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the transaction
  assign position = in_tdata[POS_W-1:0];
  assign weight   = in_tdata[POS_W +: WEIGHT_W];
  assign gidx     = in_tdata[POS_W+WEIGHT_W +: GRID_AW];

  // Cell is floor(position); keep it only if it and the next point are on the grid
  assign cell_idx = position[POS_W-1:FRAC_BITS];
  assign in_range = !cell_idx[CELL_W-1]
                 && (cell_idx[CELL_W-2:0] < (CELL_W-1)'(lgp_r))
                 && (cell_idx[CELL_W-2:0] < (CELL_W-1)'(GRID_POINTS - 1));

  // Particle charge before rounding
  assign prod = $signed({1'b0, weight}) * scale_r;

  // Decode the operation
  always_comb begin
    unique case (in_tuser)
      OP_DEPOSIT:    kind = in_range ? K_DEPOSIT : K_DROP;
      OP_READ:       kind = K_READ;
      OP_READ_CLEAR: kind = K_READ_CLEAR;
      default:       kind = K_NONE;
    endcase
  end

  // Hold input until the grid is cleared and the queue has room
  assign in_tready = init_done && !q_full;
  assign q_push    = in_tvalid && in_tready;

  assign q_data.kind     = kind;
  assign q_data.cell_idx = cell_idx[GRID_AW-1:0];
  assign q_data.frac     = position[FRAC_BITS-1:0];
  assign q_data.prod     = prod;
  assign q_data.gidx     = gidx;
  assign q_data.last     = in_tlast;

endmodule

>>> src/cic_queue.sv
// ----------------------------------------------------------------------------
// cic_queue: short queue between front and back end
// Lets the front end keep accepting while the back end works or stalls.
// ----------------------------------------------------------------------------
module cic_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cic_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output cic_pkg::q_entry_t pop_data,
  output logic              empty
);

  import cic_pkg::*;

  q_entry_t              slots_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r;
  logic [QUEUE_AW-1:0]   rd_ptr_r;
  logic [QUEUE_AW:0]     count_r;

  assign full     = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slots_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> src/cic_back.sv
// ----------------------------------------------------------------------------
// cic_back: grid update and read execution
// Owns the charge grid as two banks (even and odd points), clears it after
// reset and runs each queued operation through a short sequencer.
// ----------------------------------------------------------------------------
module cic_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  cic_pkg::q_entry_t               q_data,
  output logic                            q_pop,
  output logic                            init_done,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cic_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);

  import cic_pkg::*;

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DATA = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;

  logic [2:0]                 state_r;
  logic [BANK_AW-1:0]         init_cnt_r;
  logic [KIND_W-1:0]          kind_r;
  logic                       odd_cell_r;
  logic                       gsel_r;
  logic [FRAC_BITS-1:0]       frac_r;
  logic                       last_r;
  logic [BANK_AW-1:0]         even_addr_r;
  logic [BANK_AW-1:0]         odd_addr_r;
  logic signed [W_W-1:0]      w_r;
  logic signed [MPROD_W-1:0]  mprod_r;
  logic signed [SHARE_W-1:0]  upper_r;
  logic signed [SHARE_W-1:0]  lower_r;

  logic                       out_valid_r;
  logic [ACC_W-1:0]           out_value_r;
  logic                       out_dep_r;
  logic                       out_sat_r;
  logic                       out_last_r;

  logic                       out_free;
  logic                       head_dep;
  logic [GRID_AW-1:0]         cell_p1;
  logic [BANK_AW-1:0]         even_raddr;
  logic [BANK_AW-1:0]         odd_raddr;
  logic signed [PROD_W-1:0]   w_sum;
  logic signed [MPROD_W-1:0]  u_sum;
  logic signed [SHARE_W-1:0]  upper_nxt;
  logic signed [SHARE_W-1:0]  even_add;
  logic signed [SHARE_W-1:0]  odd_add;
  logic signed [ACC_W:0]      even_sum;
  logic signed [ACC_W:0]      odd_sum;
  logic                       even_clip;
  logic                       odd_clip;
  logic [ACC_W-1:0]           even_sat;
  logic [ACC_W-1:0]           odd_sat;
  logic [ACC_W-1:0]           even_rd;
  logic [ACC_W-1:0]           odd_rd;

  logic                       even_we;
  logic                       odd_we;
  logic [BANK_AW-1:0]         even_waddr;
  logic [BANK_AW-1:0]         odd_waddr;
  logic [ACC_W-1:0]           even_wdata;
  logic [ACC_W-1:0]           odd_wdata;

  // Grid banks: even points in one, odd points in the other
  cic_ram #(.WIDTH(ACC_W), .DEPTH(BANK_DEPTH)) u_even (
    .clk     (clk),
    .wr_en   (even_we),
    .wr_addr (even_waddr),
    .wr_data (even_wdata),
    .rd_en   (q_pop),
    .rd_addr (even_raddr),
    .rd_data (even_rd)
  );

  cic_ram #(.WIDTH(ACC_W), .DEPTH(BANK_DEPTH)) u_odd (
    .clk     (clk),
    .wr_en   (odd_we),
    .wr_addr (odd_waddr),
    .wr_data (odd_wdata),
    .rd_en   (q_pop),
    .rd_addr (odd_raddr),
    .rd_data (odd_rd)
  );

  // Take the next operation once the output register is free
  assign init_done = (state_r != ST_INIT);
  assign out_free  = !out_valid_r || out_tready;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty && out_free;

  // Read addresses: a cell and its neighbour always sit in different banks
  assign head_dep   = (q_data.kind == K_DEPOSIT);
  assign cell_p1    = q_data.cell_idx + 1'b1;
  assign even_raddr = head_dep ? cell_p1[GRID_AW-1:1] : q_data.gidx[GRID_AW-1:1];
  assign odd_raddr  = head_dep ? q_data.cell_idx[GRID_AW-1:1] : q_data.gidx[GRID_AW-1:1];

  // Round the particle charge, half up
  assign w_sum = $signed(q_data.prod) + $signed(PROD_W'(1 << (FRAC_BITS - 1)));

  // Round the share of the next grid point, half up
  assign u_sum     = mprod_r + $signed(MPROD_W'(1 << (FRAC_BITS - 1)));
  assign upper_nxt = u_sum[FRAC_BITS +: SHARE_W];

  // Saturating accumulate into both points
  assign even_add  = odd_cell_r ? upper_r : lower_r;
  assign odd_add   = odd_cell_r ? lower_r : upper_r;
  assign even_sum  = $signed(even_rd) + even_add;
  assign odd_sum   = $signed(odd_rd) + odd_add;
  assign even_clip = (even_sum[ACC_W] != even_sum[ACC_W-1]);
  assign odd_clip  = (odd_sum[ACC_W] != odd_sum[ACC_W-1]);
  assign even_sat  = even_clip ? (even_sum[ACC_W] ? ACC_MIN : ACC_MAX) : even_sum[ACC_W-1:0];
  assign odd_sat   = odd_clip ? (odd_sum[ACC_W] ? ACC_MIN : ACC_MAX) : odd_sum[ACC_W-1:0];

  // Bank write control
  always_comb begin
    even_we    = 1'b0;
    odd_we     = 1'b0;
    even_waddr = even_addr_r;
    odd_waddr  = odd_addr_r;
    even_wdata = '0;
    odd_wdata  = '0;
    unique case (state_r)
      ST_INIT: begin
        even_we    = 1'b1;
        odd_we     = 1'b1;
        even_waddr = init_cnt_r;
        odd_waddr  = init_cnt_r;
      end
      ST_DATA: begin
        if (kind_r == K_READ_CLEAR) begin
          even_we = !gsel_r;
          odd_we  = gsel_r;
        end
      end
      ST_ACC: begin
        even_we    = 1'b1;
        odd_we     = 1'b1;
        even_wdata = even_sat;
        odd_wdata  = odd_sat;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      init_cnt_r <= '0;
    end else begin
      unique case (state_r)
        ST_INIT: begin
          init_cnt_r <= init_cnt_r + 1'b1;
          if (init_cnt_r == BANK_AW'(BANK_DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop && (q_data.kind == K_DEPOSIT || q_data.kind == K_READ
                        || q_data.kind == K_READ_CLEAR)) begin
            state_r <= ST_DATA;
          end
        end
        ST_DATA: state_r <= (kind_r == K_DEPOSIT) ? ST_RND : ST_IDLE;
        ST_RND:  state_r <= ST_ACC;
        ST_ACC:  state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Working registers of the current operation
  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r      <= q_data.kind;
      odd_cell_r  <= q_data.cell_idx[0];
      gsel_r      <= q_data.gidx[0];
      frac_r      <= q_data.frac;
      last_r      <= q_data.last;
      even_addr_r <= even_raddr;
      odd_addr_r  <= odd_raddr;
      w_r         <= w_sum[FRAC_BITS +: W_W];
    end
    if (state_r == ST_DATA) begin
      mprod_r <= w_r * $signed({1'b0, frac_r});
    end
    if (state_r == ST_RND) begin
      upper_r <= upper_nxt;
      lower_r <= $signed(SHARE_W'(w_r)) - upper_nxt;
    end
  end

  // Output register: load when an operation completes, else drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop && (q_data.kind == K_DROP || q_data.kind == K_NONE)) begin
        out_valid_r <= 1'b1;
      end else if (state_r == ST_DATA && kind_r != K_DEPOSIT) begin
        out_valid_r <= 1'b1;
      end else if (state_r == ST_ACC) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_data.kind == K_DROP || q_data.kind == K_NONE)) begin
      out_value_r <= '0;
      out_dep_r   <= 1'b0;
      out_sat_r   <= 1'b0;
      out_last_r  <= (q_data.kind == K_DROP) ? q_data.last : 1'b0;
    end else if (state_r == ST_DATA && kind_r != K_DEPOSIT) begin
      out_value_r <= gsel_r ? odd_rd : even_rd;
      out_dep_r   <= 1'b0;
      out_sat_r   <= 1'b0;
      out_last_r  <= 1'b0;
    end else if (state_r == ST_ACC) begin
      out_value_r <= '0;
      out_dep_r   <= 1'b1;
      out_sat_r   <= even_clip || odd_clip;
      out_last_r  <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W-ACC_W-2)'(0), out_sat_r, out_dep_r, out_value_r};
  assign out_tlast  = out_last_r;

endmodule

>>> src/cloud_in_cell_charge_deposit.sv
// ----------------------------------------------------------------------------
// cloud_in_cell_charge_deposit: 1-D cloud-in-cell charge deposition
// Input stream carries deposit, read and read-and-clear transactions; the
// output stream returns one result per input transaction.
//
// Usage:
//   in_tuser selects the operation (deposit, read, read and clear). A deposit
//   splits weight * charge_scale between the cell under the particle and the
//   next grid point, saturating each 40-bit accumulator. Reads return one
//   grid value. Registers must be written through cfg_we/cfg_addr/cfg_wdata
//   only while the block is idle; the block itself does not enforce this.
//   After reset the grid is swept to zero, one row of both banks per cycle;
//   in_tready stays low until the sweep is done. An accepted transaction
//   enters a two-entry queue; the back end pops it when idle with the output
//   register free, and takes no new operation before the current one is
//   done. A deposit passes through bank read, offset multiply, rounding and
//   saturating write back, a read through bank read and result load;
//   out-of-range deposits and unused codes load their result on the pop.
//   When out_tready is low the result is held in the output register, the
//   back end stops, and the queue keeps taking input until it is full.
// ----------------------------------------------------------------------------
module cloud_in_cell_charge_deposit (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: position[27:0], weight[45:28], grid_index[55:46]
  input  logic [cic_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: op[1:0]
  input  logic [cic_pkg::OP_W-1:0]        in_tuser,
  input  logic                            in_tlast,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // out_tdata: charge_value[39:0], deposited[40], saturated[41], zero[47:42]
  output logic [cic_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [cic_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [cic_pkg::CFG_DW-1:0]      cfg_wdata
);

  import cic_pkg::*;

  q_entry_t push_data;
  q_entry_t pop_data;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  logic     init_done;

  // Accept and classify
  cic_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .init_done (init_done),
    .q_full    (q_full),
    .q_push    (push),
    .q_data    (push_data)
  );

  // Decouple front and back end
  cic_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // Execute against the grid
  cic_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (pop_data),
    .q_pop      (pop),
    .init_done  (init_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the cloud-in-cell charge deposition block
// Opens with a table of deposit, read, read-and-clear and unused-code
// transactions, then runs random phases under several charge scales and last
// grid points, ending with a full-weight deposit burst on cell zero with no
// idling. A behavioural grid model predicts each result not typed into the
// table, and each output transaction is compared field by field, in order,
// with the expected result. Both stream sides idle in random bursts while idling is on.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cic_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam longint          CHARGE_MAX  = 64'sd549755813887;
  localparam longint          CHARGE_MIN  = -CHARGE_MAX - 1;
  localparam longint          ROUND_HALF  = longint'(1) << (FRAC_BITS - 1);
  localparam longint          FRAC_MASK   = (longint'(1) << FRAC_BITS) - 1;
  localparam int              CYCLE_LIMIT = 1000000;
  localparam int              PHASES      = 7;
  localparam int              PHASE_ITEMS = 190;

  typedef struct packed {
    logic [ACC_W-1:0] charge;
    logic             deposited;
    logic             saturated;
    logic             pass_done;
    logic [5:0]       pad;
  } charge_result_t;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [POS_W-1:0]    pos;
    logic [WEIGHT_W-1:0] wt;
    logic [GRID_AW-1:0]  gidx;
    logic                last;
    bit                  typed;
    charge_result_t      want;
  } probe_row_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [OP_W-1:0]        in_tuser  = '0;
  logic                   in_tlast  = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr  = '0;
  logic [CFG_DW-1:0]      cfg_wdata = '0;

  // Grid model and register copies
  longint               grid_charge [GRID_POINTS];
  logic [SCALE_W-1:0]   scale_setting      = SCALE_RESET;
  logic [LGP_W-1:0]     last_point_setting = LGP_RESET;

  charge_result_t charge_results_due[$];
  probe_row_t     probe_table[$];
  int             fault_count = 0;
  int             cycle_count = 0;
  int             stall_left  = 0;
  bit             idle_on     = 1'b1;

  cloud_in_cell_charge_deposit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Clamp a sum to the 40-bit accumulator range
  function automatic longint clip_charge(longint sum);
    if (sum > CHARGE_MAX) return CHARGE_MAX;
    if (sum < CHARGE_MIN) return CHARGE_MIN;
    return sum;
  endfunction

  // Work out one result and advance the grid model
  function automatic charge_result_t predict_charge(logic [OP_W-1:0] op,
      logic [POS_W-1:0] pos, logic [WEIGHT_W-1:0] wt, logic [GRID_AW-1:0] gidx,
      logic last);
    charge_result_t r;
    longint p, cell_idx, frac, w, upper, lower, sum_lo, sum_hi, stored;
    r = '0;
    case (op) inside
      OP_DEPOSIT: begin
        p = longint'($signed(pos));
        cell_idx = p >>> FRAC_BITS;
        frac = p & FRAC_MASK;
        r.pass_done = last;
        if (cell_idx >= 0 && cell_idx < longint'(last_point_setting)
            && cell_idx + 1 < GRID_POINTS) begin
          w = (longint'(wt) * longint'($signed(scale_setting)) + ROUND_HALF) >>> FRAC_BITS;
          upper = (w * frac + ROUND_HALF) >>> FRAC_BITS;
          lower = w - upper;
          sum_lo = grid_charge[cell_idx] + lower;
          sum_hi = grid_charge[cell_idx + 1] + upper;
          grid_charge[cell_idx] = clip_charge(sum_lo);
          grid_charge[cell_idx + 1] = clip_charge(sum_hi);
          r.deposited = 1'b1;
          r.saturated = (clip_charge(sum_lo) != sum_lo) || (clip_charge(sum_hi) != sum_hi);
        end
      end
      OP_READ, OP_READ_CLEAR: begin
        stored = grid_charge[gidx];
        r.charge = stored[ACC_W-1:0];
        if (op == OP_READ_CLEAR) grid_charge[gidx] = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic probe_row_t probe(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
      logic [WEIGHT_W-1:0] wt, logic [GRID_AW-1:0] gidx, logic last, bit typed,
      logic [ACC_W-1:0] charge, logic dep, logic done);
    probe_row_t row;
    row.op = op;
    row.pos = pos;
    row.wt = wt;
    row.gidx = gidx;
    row.last = last;
    row.typed = typed;
    row.want = '0;
    row.want.charge = charge;
    row.want.deposited = dep;
    row.want.pass_done = done;
    return row;
  endfunction

  // Offer one transaction, hold until accepted, then queue its result
  task automatic send_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
      logic [WEIGHT_W-1:0] wt, logic [GRID_AW-1:0] gidx, logic last,
      bit use_given, charge_result_t given);
    bit took;
    charge_result_t predicted;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {gidx, wt, pos};
    in_tuser <= op;
    in_tlast <= last;
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    predicted = predict_charge(op, pos, wt, gidx, last);
    charge_results_due.push_back(use_given ? given : predicted);
  endtask

  // Stop offering and wait until every result is back and the pipe is quiet
  task automatic drain;
    in_tvalid <= 1'b0;
    while (charge_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CHARGE_SCALE) scale_setting = data[SCALE_W-1:0];
    else last_point_setting = data[LGP_W-1:0];
    @(posedge clk);
  endtask

  // Random traffic focused on a small window of cells so reads see charge
  task automatic drive_random_items(int count);
    int k, pick, base, cell_pick;
    logic [POS_W-1:0]    pos;
    logic [WEIGHT_W-1:0] wt;
    logic [GRID_AW-1:0]  gidx;
    logic [OP_W-1:0]     op;
    base = (last_point_setting > 16) ? $urandom_range(0, last_point_setting - 16) : 0;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 19);
      op = (pick < 11) ? OP_DEPOSIT : (pick < 15) ? OP_READ :
           (pick < 19) ? OP_READ_CLEAR : OP_UNUSED;
      pick = $urandom_range(0, 9);
      if (pick == 0) cell_pick = 0;
      else if (pick == 1) cell_pick = int'(last_point_setting) + $urandom_range(0, 1) - 1;
      else cell_pick = base + $urandom_range(0, 15);
      pos = (pick == 0) ? POS_W'($urandom)
                        : {cell_pick[CELL_W-1:0], FRAC_BITS'($urandom)};
      pick = $urandom_range(0, 7);
      wt = (pick == 0) ? '0 : (pick == 1) ? '1 : WEIGHT_W'($urandom);
      gidx = ($urandom_range(0, 3) != 0) ? GRID_AW'(base + $urandom_range(0, 16))
                                          : GRID_AW'($urandom);
      send_op(op, pos, wt, gidx, 1'($urandom), 1'b0, '0);
    end
  endtask

  // Receiver: random stall bursts while idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each output transaction with the oldest prediction
  always @(negedge clk) begin
    charge_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.charge = out_tdata[ACC_W-1:0];
      got.deposited = out_tdata[ACC_W];
      got.saturated = out_tdata[ACC_W+1];
      got.pass_done = out_tlast;
      got.pad = out_tdata[OUT_TDATA_W-1:ACC_W+2];
      if (charge_results_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result: tdata %h tlast %b", out_tdata, out_tlast);
      end else begin
        want = charge_results_due.pop_front();
        if (got.charge !== want.charge || got.deposited !== want.deposited ||
            got.saturated !== want.saturated || got.pass_done !== want.pass_done ||
            got.pad !== want.pad) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch: charge %h/%h dep %b/%b sat %b/%b done %b/%b pad %h/%h",
                     want.charge, got.charge, want.deposited, got.deposited,
                     want.saturated, got.saturated, want.pass_done, got.pass_done,
                     want.pad, got.pad);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [SCALE_W-1:0] scale_plan [PHASES];
    logic [LGP_W-1:0]   lgp_plan [PHASES];
    int ph, n;

    foreach (grid_charge[i]) grid_charge[i] = 0;

    // Directed table: extremes, every code and the out-of-range cases
    probe_table.push_back(probe(OP_READ, 28'h0, 18'h0, 10'd0, 1'b0, 1, '0, 0, 0));
    probe_table.push_back(probe(OP_READ, 28'hFFFFFFF, 18'h3FFFF, 10'd1023, 1'b1, 1, '0, 0, 0));
    probe_table.push_back(probe(OP_READ_CLEAR, 28'h0, 18'h0, 10'd512, 1'b0, 1, '0, 0, 0));
    probe_table.push_back(probe(OP_UNUSED, 28'hFFFFFFF, 18'h3FFFF, 10'd1023, 1'b1, 1, '0, 0, 0));
    probe_table.push_back(probe(OP_DEPOSIT, 28'hFFFFFFF, 18'h3FFFF, 10'd0, 1'b1, 1, '0, 0, 1));
    probe_table.push_back(probe(OP_DEPOSIT, 28'h8000000, 18'h3FFFF, 10'd0, 1'b0, 1, '0, 0, 0));
    probe_table.push_back(probe(OP_DEPOSIT, 28'h7FFFFFF, 18'h3FFFF, 10'd0, 1'b1, 1, '0, 0, 1));
    probe_table.push_back(probe(OP_DEPOSIT, 28'h3FF0000, 18'h10000, 10'd0, 1'b0, 1, '0, 0, 0));
    probe_table.push_back(probe(OP_DEPOSIT, 28'h0000000, 18'h3FFFF, 10'd0, 1'b1, 0, '0, 0, 0));
    probe_table.push_back(probe(OP_DEPOSIT, 28'h3FEFFFF, 18'h3FFFF, 10'd0, 1'b0, 0, '0, 0, 0));
    probe_table.push_back(probe(OP_DEPOSIT, 28'h0058000, 18'h10000, 10'd0, 1'b0, 0, '0, 0, 0));
    probe_table.push_back(probe(OP_DEPOSIT, 28'h0050000, 18'h00000, 10'd0, 1'b1, 0, '0, 0, 0));
    probe_table.push_back(probe(OP_DEPOSIT, 28'h0060001, 18'h00001, 10'd0, 1'b0, 0, '0, 0, 0));
    probe_table.push_back(probe(OP_READ, 28'h0, 18'h0, 10'd0, 1'b0, 0, '0, 0, 0));
    probe_table.push_back(probe(OP_READ, 28'h0, 18'h0, 10'd1, 1'b1, 0, '0, 0, 0));
    probe_table.push_back(probe(OP_READ_CLEAR, 28'h0, 18'h0, 10'd1022, 1'b0, 0, '0, 0, 0));
    probe_table.push_back(probe(OP_READ, 28'h0, 18'h0, 10'd1023, 1'b0, 0, '0, 0, 0));
    probe_table.push_back(probe(OP_READ_CLEAR, 28'h0, 18'h0, 10'd1023, 1'b0, 0, '0, 0, 0));
    probe_table.push_back(probe(OP_READ, 28'h0, 18'h0, 10'd1023, 1'b0, 1, '0, 0, 0));
    probe_table.push_back(probe(OP_READ, 28'h0, 18'h0, 10'd5, 1'b0, 0, '0, 0, 0));
    probe_table.push_back(probe(OP_READ_CLEAR, 28'h0, 18'h0, 10'd6, 1'b0, 0, '0, 0, 0));
    probe_table.push_back(probe(OP_READ, 28'h0, 18'h0, 10'd6, 1'b0, 1, '0, 0, 0));

    // Register settings per random phase, extremes first
    scale_plan[0] = SCALE_W'($urandom);  lgp_plan[0] = 10'd1023;
    scale_plan[1] = 24'h7FFFFF;          lgp_plan[1] = 10'd1;
    scale_plan[2] = 24'h800000;          lgp_plan[2] = 10'd0;
    scale_plan[3] = 24'h000000;          lgp_plan[3] = LGP_W'($urandom_range(1, 1023));
    scale_plan[4] = 24'hFFFFFF;          lgp_plan[4] = 10'd512;
    scale_plan[5] = SCALE_W'($urandom);  lgp_plan[5] = LGP_W'($urandom_range(1, 1023));
    scale_plan[6] = SCALE_W'($urandom);  lgp_plan[6] = LGP_W'($urandom_range(2, 1023));

    // Hold reset, then release
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probe_table[i])
      send_op(probe_table[i].op, probe_table[i].pos, probe_table[i].wt, probe_table[i].gidx,
              probe_table[i].last, probe_table[i].typed, probe_table[i].want);
    drain();

    // Random phases, each under its own register setting
    for (ph = 0; ph < PHASES; ph++) begin
      idle_on = (ph % 3 != 2) && (ph != PHASES - 1);
      write_register(REG_CHARGE_SCALE, scale_plan[ph]);
      write_register(REG_LAST_GRID_POINT, {14'($urandom), lgp_plan[ph]});
      drive_random_items(PHASE_ITEMS);
      drain();
    end

    // Pile full-weight charge onto cell zero, back to back
    idle_on = 1'b0;
    write_register(REG_CHARGE_SCALE, 24'h7FFFFF);
    write_register(REG_LAST_GRID_POINT, {14'h0, LGP_RESET});
    for (n = 0; n < 8; n++)
      send_op(OP_DEPOSIT, '0, '1, GRID_AW'($urandom), 1'($urandom), 1'b0, '0);
    for (n = 0; n < 6; n++)
      send_op(OP_DEPOSIT, {12'h0, FRAC_BITS'($urandom)}, '1, '0, 1'($urandom), 1'b0, '0);
    send_op(OP_READ, '0, '0, 10'd0, 1'b0, 1'b0, '0);
    send_op(OP_READ, '0, '0, 10'd1, 1'b0, 1'b0, '0);
    send_op(OP_READ_CLEAR, '0, '0, 10'd0, 1'b0, 1'b0, '0);
    send_op(OP_READ, '0, '0, 10'd0, 1'b0, 1'b0, '0);
    drain();

    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> cloud_in_cell_charge_deposit.f
src/cic_pkg.sv
src/cic_ram.sv
src/cic_front.sv
src/cic_queue.sv
src/cic_back.sv
src/cloud_in_cell_charge_deposit.sv
tb/tb_top.sv
